### rtl/rsu_pkg.sv
// shared types, codes and the tanh table of the reservoir state update block
package rsu_pkg;

   // input transaction fields
   typedef struct packed {
      logic [2:0]         func;
      logic [6:0]         unit;
      logic [3:0]         slot;
      logic [6:0]         source;
      logic signed [15:0] weight;
      logic signed [15:0] input_coeff;
      logic signed [15:0] bias_coeff;
      logic               nonlinear;
      logic signed [19:0] value;
   } req_type;

   // result transaction fields
   typedef struct packed {
      logic signed [19:0] read_value;
      logic [7:0]         clip_count;
   } rsp_type;

   // function codes
   localparam logic [2:0] FUNC_LOAD_CONN  = 3'd0;
   localparam logic [2:0] FUNC_LOAD_COEFF = 3'd1;
   localparam logic [2:0] FUNC_WRITE      = 3'd2;
   localparam logic [2:0] FUNC_STEP       = 3'd3;
   localparam logic [2:0] FUNC_READ       = 3'd4;

   // configuration register indexes
   localparam logic CSR_UNITS_USED = 1'b0;
   localparam logic CSR_TAPS_USED  = 1'b1;

   // reset values of the configuration registers
   localparam logic [7:0] UNITS_USED_RESET = 8'd100;
   localparam logic [4:0] TAPS_USED_RESET  = 5'd10;

   // datapath widths
   localparam int ACC_W  = 48;
   localparam int PROD_W = 36;
   localparam int Y_W    = 36;

   // clip bound, 100.0 in q.12
   localparam logic signed [Y_W-1:0] STATE_MAX = 36'sd409600;
   localparam logic signed [Y_W-1:0] STATE_MIN = -36'sd409600;
   // tanh saturates past 5.0
   localparam logic [Y_W-1:0] TANH_SAT = 36'd20480;

   // tanh(k/4) in q.12
   function automatic logic [12:0] tanh_tab(input logic [4:0] k);
      logic [12:0] r;
      case (k)
         5'd0:    r = 13'd0;
         5'd1:    r = 13'd1003;
         5'd2:    r = 13'd1893;
         5'd3:    r = 13'd2602;
         5'd4:    r = 13'd3119;
         5'd5:    r = 13'd3475;
         5'd6:    r = 13'd3707;
         5'd7:    r = 13'd3856;
         5'd8:    r = 13'd3949;
         5'd9:    r = 13'd4006;
         5'd10:   r = 13'd4041;
         5'd11:   r = 13'd4062;
         5'd12:   r = 13'd4076;
         5'd13:   r = 13'd4084;
         5'd14:   r = 13'd4089;
         5'd15:   r = 13'd4091;
         5'd16:   r = 13'd4093;
         5'd17:   r = 13'd4094;
         5'd18:   r = 13'd4095;
         5'd19:   r = 13'd4095;
         5'd20:   r = 13'd4096;
         default: r = 13'd4096;
      endcase
      return r;
   endfunction

endpackage

### rtl/reservoir_state_update.sv
// top level of the sparse echo-state reservoir update block
// Usage:
// - req_valid/req_stall/req_data carry one transaction: load a connection,
//   load unit coefficients, write a state, step the reservoir, read a state.
// - every request gives exactly one response on rsp_valid/rsp_stall/rsp_data.
// - loads and writes answer the cycle after acceptance; a read via S_READ.
// - a step runs one shared multiplier over every used unit: per unit it
//   issues the taps, input and bias terms, drains the pipeline, rounds,
//   interpolates tanh and writes; then a copy pass moves the new
//   states into the state memory.
// - one transaction is in work at a time; req_stall is high while it runs
//   and while a finished response waits on a stalled receiver.
// - csr_we writes units_used (index 0) or taps_used (index 1); write only
//   while the block is idle.
// - reset clears control state, states and activation types, presets
//   registers; connection and coefficient memories hold garbage until loaded.
// - a stalled response holds its value until taken.
module reservoir_state_update #(
   parameter int UNITS = 128,
   parameter int FANIN = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsu_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);
   import rsu_pkg::*;

   localparam int UA = $clog2(UNITS);
   localparam int CA = $clog2(UNITS * FANIN);
   localparam int NW = $clog2(UNITS + 1);
   localparam int TW = $clog2(FANIN + 1) + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_ISSUE, S_DRAIN, S_ROUND, S_TANH, S_WRITE, S_COPY, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      K_TAP, K_INPUT, K_BIAS
   } kind_type;

   // control and config registers
   state_type            state_ff;
   logic [7:0]           units_used_ff;
   logic [4:0]           taps_used_ff;
   logic [UNITS-1:0]     st_vld_ff;
   logic [UNITS-1:0]     is_tanh_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic [NW-1:0]        n_ff;
   logic [NW-1:0]        c_ff;
   logic [CA-1:0]        base_ff;
   logic [TW-1:0]        t_ff;
   logic [7:0]           clip_ff;
   logic signed [19:0]   sample_ff;
   logic [UA-1:0]        rd_idx_ff;
   logic                 rd_ok_ff;
   logic                 cp_vld_ff;
   logic [UA-1:0]        cp_addr_ff;

   // term pipeline
   logic                 p1_vld_ff;
   kind_type             p1_kind_ff;
   logic                 p2_vld_ff;
   kind_type             p2_kind_ff;
   logic signed [15:0]   p2_w_ff;
   logic                 p2_src_ok_ff;
   logic [UA-1:0]        p2_src_idx_ff;
   logic                 p3_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [Y_W-1:0]    y_ff;

   // memory ports
   logic                 conn_we;
   logic [CA-1:0]        conn_waddr;
   logic [22:0]          conn_wdata;
   logic [CA-1:0]        conn_raddr;
   logic [22:0]          conn_rdata;
   logic                 coef_we;
   logic [UA-1:0]        coef_waddr;
   logic [31:0]          coef_rdata;
   logic                 st_we;
   logic [UA-1:0]        st_waddr;
   logic [19:0]          st_wdata;
   logic [UA-1:0]        st_raddr;
   logic [19:0]          st_rdata;
   logic                 nx_we;
   logic [19:0]          nx_wdata;
   logic [19:0]          nx_rdata;

   // combinational helpers
   logic                 req_acc;
   logic                 rsp_free;
   logic                 unit_ok;
   logic                 slot_ok;
   logic [UA-1:0]        req_unit_addr;
   logic [NW-1:0]        nu;
   logic [TW-1:0]        nt;
   logic [6:0]           c_src;
   logic                 c_src_ok;
   logic [UA-1:0]        c_src_idx;
   logic signed [15:0]   mul_a;
   logic signed [19:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [19:0]   st_term;
   logic [Y_W-1:0]       ya;
   logic                 y_neg;
   logic                 y_big;
   logic [4:0]           ti;
   logic [12:0]          t_lo;
   logic [12:0]          t_hi;
   logic [12:0]          mag;
   logic signed [PROD_W-1:0] frac_r;
   logic [19:0]          tanh_val;
   logic [19:0]          lin_val;
   logic                 lin_clip;
   logic signed [ACC_W-1:0]  acc_r;
   kind_type             issue_kind;

   // handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // address decode of the request
   assign unit_ok       = 32'(req_data.unit) < UNITS;
   assign slot_ok       = 32'(req_data.slot) < FANIN;
   assign req_unit_addr = UA'(req_data.unit);

   // saturated unit and tap counts
   assign nu = (32'(units_used_ff) > UNITS) ? NW'(UNITS) : NW'(units_used_ff);
   assign nt = (32'(taps_used_ff) > FANIN) ? TW'(FANIN) : TW'(taps_used_ff);

   // connection source read out of the connection memory
   assign c_src     = conn_rdata[22:16];
   assign c_src_ok  = 32'(c_src) < UNITS;
   assign c_src_idx = UA'(c_src);

   // term kind issued this cycle
   always_comb begin
      if (t_ff < nt) begin
         issue_kind = K_TAP;
      end else if (t_ff == nt) begin
         issue_kind = K_INPUT;
      end else begin
         issue_kind = K_BIAS;
      end
   end

   // tanh interpolation pieces from the rounded sum
   assign y_neg  = y_ff[Y_W-1];
   assign ya     = y_neg ? Y_W'(-y_ff) : Y_W'(y_ff);
   assign y_big  = ya >= TANH_SAT;
   assign ti     = ya[14:10];
   assign t_lo   = tanh_tab(ti);
   assign t_hi   = tanh_tab(ti + 5'd1);
   assign frac_r = (prod_ff + PROD_W'(512)) >>> 10;
   assign mag    = y_big ? tanh_tab(5'd20) : t_lo + 13'(frac_r);
   assign tanh_val = y_neg ? 20'(-$signed({1'b0, mag})) : 20'(mag);

   // clipped linear activation
   always_comb begin
      lin_clip = 1'b0;
      lin_val  = 20'(y_ff);
      if (y_ff > STATE_MAX) begin
         lin_clip = 1'b1;
         lin_val  = 20'(STATE_MAX);
      end else if (y_ff < STATE_MIN) begin
         lin_clip = 1'b1;
         lin_val  = 20'(STATE_MIN);
      end
   end

   // shared multiplier operand select
   assign st_term = (p2_src_ok_ff && st_vld_ff[p2_src_idx_ff]) ? $signed(st_rdata) : 20'sd0;
   always_comb begin
      mul_a = p2_w_ff;
      mul_b = st_term;
      if (state_ff == S_TANH) begin
         mul_a = 16'($signed({1'b0, t_hi}) - $signed({1'b0, t_lo}));
         mul_b = $signed({10'd0, ya[9:0]});
      end else begin
         case (p2_kind_ff)
            K_TAP: begin
               mul_a = p2_w_ff;
               mul_b = st_term;
            end
            K_INPUT: begin
               mul_a = $signed(coef_rdata[31:16]);
               mul_b = sample_ff;
            end
            K_BIAS: begin
               mul_a = $signed(coef_rdata[15:0]);
               mul_b = 20'sd4096;
            end
            default: begin
               mul_a = 16'sd0;
               mul_b = 20'sd0;
            end
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   assign acc_r = acc_ff + ACC_W'(4096);

   // memory port select
   always_comb begin
      conn_we    = req_acc && (req_data.func == FUNC_LOAD_CONN) && unit_ok && slot_ok;
      conn_waddr = CA'(32'(req_data.unit) * FANIN + 32'(req_data.slot));
      conn_wdata = {req_data.source, req_data.weight};
      conn_raddr = base_ff + CA'(t_ff);
      coef_we    = req_acc && (req_data.func == FUNC_LOAD_COEFF) && unit_ok;
      coef_waddr = req_unit_addr;
      nx_we      = (state_ff == S_WRITE);
      nx_wdata   = is_tanh_ff[n_ff[UA-1:0]] ? tanh_val : lin_val;
      if (cp_vld_ff) begin
         st_we    = 1'b1;
         st_waddr = cp_addr_ff;
         st_wdata = nx_rdata;
      end else begin
         st_we    = req_acc && (req_data.func == FUNC_WRITE) && unit_ok;
         st_waddr = req_unit_addr;
         st_wdata = req_data.value;
      end
      case (state_ff)
         S_IDLE:  st_raddr = req_unit_addr;
         S_READ:  st_raddr = rd_idx_ff;
         default: st_raddr = c_src_idx;
      endcase
   end

   rsu_ram #(.WIDTH(23), .DEPTH(UNITS * FANIN)) u_conn_ram (
      .clock   (clock),
      .wr_en   (conn_we),
      .wr_addr (conn_waddr),
      .wr_data (conn_wdata),
      .rd_addr (conn_raddr),
      .rd_data (conn_rdata)
   );

   rsu_ram #(.WIDTH(32), .DEPTH(UNITS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data ({req_data.input_coeff, req_data.bias_coeff}),
      .rd_addr (n_ff[UA-1:0]),
      .rd_data (coef_rdata)
   );

   rsu_ram #(.WIDTH(20), .DEPTH(UNITS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   rsu_ram #(.WIDTH(20), .DEPTH(UNITS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (n_ff[UA-1:0]),
      .wr_data (nx_wdata),
      .rd_addr (c_ff[UA-1:0]),
      .rd_data (nx_rdata)
   );

   // sequencer, pipeline and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         units_used_ff <= UNITS_USED_RESET;
         taps_used_ff  <= TAPS_USED_RESET;
         st_vld_ff     <= '0;
         is_tanh_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         p3_vld_ff     <= 1'b0;
         cp_vld_ff     <= 1'b0;
         n_ff          <= '0;
         c_ff          <= '0;
         t_ff          <= '0;
         base_ff       <= '0;
         clip_ff       <= '0;
      end else begin
         // config writes
         if (csr_we) begin
            if (csr_index == CSR_UNITS_USED) begin
               units_used_ff <= csr_wdata;
            end else begin
               taps_used_ff <= csr_wdata[4:0];
            end
         end

         // response taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // term pipeline advance
         p1_vld_ff     <= (state_ff == S_ISSUE);
         p1_kind_ff    <= issue_kind;
         p2_vld_ff     <= p1_vld_ff;
         p2_kind_ff    <= p1_kind_ff;
         p2_w_ff       <= $signed(conn_rdata[15:0]);
         p2_src_ok_ff  <= c_src_ok;
         p2_src_idx_ff <= c_src_idx;
         p3_vld_ff     <= p2_vld_ff;
         if (p2_vld_ff || state_ff == S_TANH) begin
            prod_ff <= mul_p;
         end
         if (p3_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end

         // state memory write-back marks entries valid
         if (st_we) begin
            st_vld_ff[st_waddr] <= 1'b1;
         end
         cp_vld_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  rsp_ff.read_value <= 20'sd0;
                  rsp_ff.clip_count <= 8'd0;
                  case (req_data.func)
                     FUNC_LOAD_COEFF: begin
                        if (unit_ok) begin
                           is_tanh_ff[req_unit_addr] <= req_data.nonlinear;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     FUNC_STEP: begin
                        sample_ff <= req_data.value;
                        n_ff      <= '0;
                        base_ff   <= '0;
                        t_ff      <= '0;
                        acc_ff    <= '0;
                        clip_ff   <= '0;
                        state_ff  <= (nu == '0) ? S_DONE : S_ISSUE;
                     end
                     FUNC_READ: begin
                        rd_idx_ff <= req_unit_addr;
                        rd_ok_ff  <= unit_ok;
                        state_ff  <= S_READ;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_READ: begin
               if (rsp_free) begin
                  rsp_ff.read_value <= (rd_ok_ff && st_vld_ff[rd_idx_ff]) ? st_rdata : 20'sd0;
                  rsp_ff.clip_count <= 8'd0;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            S_ISSUE: begin
               if (t_ff == nt + TW'(1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  t_ff <= t_ff + TW'(1);
               end
            end
            S_DRAIN: begin
               if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               y_ff     <= Y_W'(acc_r >>> 13);
               state_ff <= S_TANH;
            end
            S_TANH: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (!is_tanh_ff[n_ff[UA-1:0]] && lin_clip) begin
                  clip_ff <= clip_ff + 8'd1;
               end
               if (n_ff + NW'(1) < nu) begin
                  n_ff     <= n_ff + NW'(1);
                  base_ff  <= base_ff + CA'(FANIN);
                  t_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_ISSUE;
               end else begin
                  c_ff     <= '0;
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               if (c_ff < nu) begin
                  cp_vld_ff  <= 1'b1;
                  cp_addr_ff <= c_ff[UA-1:0];
                  c_ff       <= c_ff + NW'(1);
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_ff.read_value <= 20'sd0;
                  rsp_ff.clip_count <= clip_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // term pipeline is empty before a unit's sum is rounded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff))
      else $error("term pipeline not drained at rounding");

   // clip count never exceeds the units updated
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (32'(clip_ff) <= 32'(nu)))
      else $error("clip count exceeds units used");

   // a response is raised only from idle, read or done
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_READ
                               || $past(state_ff) == S_DONE))
      else $error("response raised mid step");

   // new states are copied only after the last unit is written
   assert property (@(posedge clock) disable iff (reset)
      cp_vld_ff |-> (state_ff == S_COPY || state_ff == S_DONE))
      else $error("state copy outside copy pass");

endmodule

### rtl/rsu_ram.sv
// generic single write port ram with registered read
module rsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### tb/reservoir_state_update_tb.sv
// self-checking testbench of the reservoir state update block
module reservoir_state_update_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsu_pkg::*;

   localparam int N_UNITS    = 128;
   localparam int N_TAPS     = 16;
   localparam int FULL_UNITS = 8;
   localparam int CYCLE_CAP  = 3000000;
   localparam int HOLD_LEN   = 4000;
   localparam int QUIET_NEED = 8;

   // tanh(k/4) in q.12, k = 0..20
   localparam int TANH_Q12[21] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
      4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096};

   typedef enum {OP_REQ, OP_CSR, OP_PHASE, OP_DRAIN, OP_HOLD} op_kind_type;
   typedef struct {
      op_kind_type kind;
      req_type     req;
      logic        idx;
      logic [7:0]  wdata;
      int          idle_pct;
      int          stall_pct;
   } op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;
   logic    hold_kick = 1'b0;

   op_type  pending[$];
   rsp_type expected_rsp[$];
   int      errors = 0;
   int      sent_cnt = 0;
   int      rsp_cnt = 0;
   int      quiet = 0;
   int      send_idle = 0;
   int      stall_pct = 0;
   int      hold_left = 0;
   int      cycles = 0;

   // predictor state
   logic [7:0] units_used;
   logic [4:0] taps_used;
   int   conn_w[N_UNITS*N_TAPS];
   int   conn_src[N_UNITS*N_TAPS];
   int   in_coeff[N_UNITS];
   int   bias_coeff[N_UNITS];
   bit   is_tanh[N_UNITS];
   int   state_q12[N_UNITS];
   int   new_state[N_UNITS];

   reservoir_state_update u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // interpolated tanh of a q.12 sum
   function automatic int tanh_interp(longint y);
      longint a;
      longint i;
      longint f;
      longint mag;
      a = (y < 0) ? -y : y;
      if (a >= 20480) begin
         mag = TANH_Q12[20];
      end else begin
         i = a >> 10;
         f = a & 1023;
         mag = TANH_Q12[i] + (((TANH_Q12[i+1] - TANH_Q12[i]) * f + 512) >> 10);
      end
      return (y < 0) ? int'(-mag) : int'(mag);
   endfunction

   // apply one transaction to the predicted state, return its response
   function automatic rsp_type reservoir_apply(req_type r);
      rsp_type o;
      int nu;
      int nt;
      longint acc;
      longint y;
      int clips;
      o = '0;
      clips = 0;
      case (r.func)
         FUNC_LOAD_CONN: begin
            conn_w[r.unit*N_TAPS + r.slot] = int'($signed(r.weight));
            conn_src[r.unit*N_TAPS + r.slot] = r.source;
         end
         FUNC_LOAD_COEFF: begin
            in_coeff[r.unit] = int'($signed(r.input_coeff));
            bias_coeff[r.unit] = int'($signed(r.bias_coeff));
            is_tanh[r.unit] = r.nonlinear;
         end
         FUNC_WRITE: state_q12[r.unit] = int'($signed(r.value));
         FUNC_STEP: begin
            nu = (units_used > N_UNITS) ? N_UNITS : units_used;
            nt = (taps_used > N_TAPS) ? N_TAPS : taps_used;
            for (int n = 0; n < nu; n++) begin
               acc = longint'(in_coeff[n]) * longint'($signed(r.value));
               for (int k = 0; k < nt; k++)
                  acc += longint'(conn_w[n*N_TAPS+k]) * longint'(state_q12[conn_src[n*N_TAPS+k]]);
               acc += longint'(bias_coeff[n]) * 4096;
               y = (acc + 4096) >>> 13;
               if (is_tanh[n]) begin
                  new_state[n] = tanh_interp(y);
               end else if (y > 409600) begin
                  new_state[n] = 409600;
                  clips++;
               end else if (y < -409600) begin
                  new_state[n] = -409600;
                  clips++;
               end else begin
                  new_state[n] = int'(y);
               end
            end
            for (int n = 0; n < nu; n++)
               state_q12[n] = new_state[n];
            o.clip_count = clips[7:0];
         end
         FUNC_READ: o.read_value = state_q12[r.unit][19:0];
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   // driver: feeds transactions, csr writes and phase changes from the pending queue
   always @(posedge clock) begin
      logic nv;
      req_type nd;
      logic nwe;
      logic nidx;
      logic [7:0] nwd;
      logic nkick;
      logic free;
      free = !req_valid || !req_stall;
      nv = req_valid && req_stall;
      nd = req_data;
      nwe = 1'b0;
      nidx = csr_index;
      nwd = csr_wdata;
      nkick = 1'b0;
      if (reset) begin
         nv = 1'b0;
         quiet = 0;
      end else begin
         if (req_valid && !req_stall) sent_cnt++;
         quiet = (!req_valid && !csr_we && sent_cnt == rsp_cnt) ? quiet + 1 : 0;
         if (free && pending.size() > 0) begin
            case (pending[0].kind)
               OP_REQ: begin
                  if ($urandom_range(99) >= send_idle) begin
                     nv = 1'b1;
                     nd = pending[0].req;
                     void'(pending.pop_front());
                  end
               end
               OP_PHASE: begin
                  send_idle = pending[0].idle_pct;
                  stall_pct <= pending[0].stall_pct;
                  void'(pending.pop_front());
               end
               OP_HOLD: begin
                  nkick = 1'b1;
                  void'(pending.pop_front());
               end
               default: begin
                  // csr writes and pauses wait for an idle block
                  if (quiet >= QUIET_NEED) begin
                     if (pending[0].kind == OP_CSR) begin
                        nwe = 1'b1;
                        nidx = pending[0].idx;
                        nwd = pending[0].wdata;
                     end
                     void'(pending.pop_front());
                  end
               end
            endcase
         end
      end
      req_valid <= nv;
      req_data <= nd;
      csr_we <= nwe;
      csr_index <= nidx;
      csr_wdata <= nwd;
      hold_kick <= nkick;
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_kick) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         units_used = UNITS_USED_RESET;
         taps_used = TAPS_USED_RESET;
         for (int n = 0; n < N_UNITS; n++) begin
            is_tanh[n] = 1'b0;
            state_q12[n] = 0;
            new_state[n] = 0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_UNITS_USED) units_used = csr_wdata;
            else taps_used = csr_wdata[4:0];
         end
         if (req_valid && !req_stall) expected_rsp.push_back(reservoir_apply(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_cnt <= rsp_cnt + 1;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.read_value !== e.read_value)
                  report_mismatch($sformatf("read_value %0d, expected %0d",
                     $signed(rsp_data.read_value), $signed(e.read_value)));
               if (rsp_data.clip_count !== e.clip_count)
                  report_mismatch($sformatf("clip_count %0d, expected %0d",
                     rsp_data.clip_count, e.clip_count));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_req(req_type r);
      op_type o;
      o = '{kind: OP_REQ, req: r, idx: 1'b0, wdata: 8'd0, idle_pct: 0, stall_pct: 0};
      pending.push_back(o);
   endtask

   task automatic push_op(op_kind_type kind, logic idx = 1'b0, logic [7:0] wdata = 8'd0,
                          int idle_pct = 0, int stall = 0);
      op_type o;
      o = '{kind: kind, req: '0, idx: idx, wdata: wdata, idle_pct: idle_pct,
            stall_pct: stall};
      pending.push_back(o);
   endtask

   task automatic push_setting(int units, int taps);
      push_op(OP_CSR, CSR_UNITS_USED, units[7:0]);
      push_op(OP_CSR, CSR_TAPS_USED, taps[7:0]);
   endtask

   function automatic req_type make_req(logic [2:0] func);
      req_type r;
      r = req_type'(90'({$urandom, $urandom, $urandom}));
      r.func = func;
      // keep most weights moderate so states do not just pin at the rails
      if ($urandom_range(3) != 0) begin
         r.weight = 16'($signed($urandom_range(4095)) - 2048);
         r.input_coeff = 16'($signed($urandom_range(16383)) - 8192);
         r.bias_coeff = 16'($signed($urandom_range(4095)) - 2048);
      end
      if (func == FUNC_STEP && $urandom_range(1))
         r.value = 20'($signed($urandom_range(16383)) - 8192);
      return r;
   endfunction

   function automatic req_type random_req();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return make_req(FUNC_LOAD_CONN);
      if (pick < 25) return make_req(FUNC_LOAD_COEFF);
      if (pick < 45) return make_req(FUNC_WRITE);
      if (pick < 55) return make_req(FUNC_STEP);
      if (pick < 95) return make_req(FUNC_READ);
      return make_req(3'($urandom_range(7, 5)));
   endfunction

   // stimulus and end of test
   initial begin
      req_type r;
      int settings[4][2] = '{'{8, 16}, '{128, 1}, '{8, 2}, '{100, 1}};
      int idles[4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{35, 35}};

      // fill the stores a step can reach: every unit's coefficients and
      // first slot, all slots of the first few units
      push_op(OP_PHASE, 1'b0, 8'd0, 0, 0);
      for (int u = 0; u < N_UNITS; u++) begin
         r = make_req(FUNC_LOAD_COEFF);
         r.unit = 7'(u);
         push_req(r);
         for (int s = 0; s < ((u < FULL_UNITS) ? N_TAPS : 1); s++) begin
            r = make_req(FUNC_LOAD_CONN);
            r.unit = 7'(u);
            r.slot = 4'(s);
            push_req(r);
         end
      end

      // directed: field extremes, every function, register corner cases
      r = make_req(FUNC_LOAD_CONN);
      r.unit = 7'd127; r.slot = 4'd15; r.source = 7'd127; r.weight = 16'sh8000;
      push_req(r);
      r.slot = 4'd0; r.source = 7'd0; r.weight = 16'sh7fff;
      push_req(r);
      r = make_req(FUNC_LOAD_COEFF);
      r.unit = 7'd0; r.input_coeff = 16'sh7fff; r.bias_coeff = 16'sh8000; r.nonlinear = 1'b1;
      push_req(r);
      r = make_req(FUNC_WRITE);
      r.unit = 7'd127; r.value = 20'sh80000;
      push_req(r);
      r.func = FUNC_READ;
      push_req(r);
      r = make_req(FUNC_WRITE);
      r.unit = 7'd0; r.value = 20'sh7ffff;
      push_req(r);
      r.func = FUNC_READ;
      push_req(r);
      r = make_req(FUNC_WRITE);
      r.unit = 7'd1; r.value = 20'sd409600;
      push_req(r);
      for (int f = 5; f < 8; f++) push_req(make_req(3'(f)));
      // unit count saturates
      push_setting(255, 1);
      r = make_req(FUNC_STEP);
      r.value = 20'sh7ffff;
      push_req(r);
      r.value = 20'sh80000;
      push_req(r);
      // tap count saturates
      push_setting(FULL_UNITS, 31);
      push_req(make_req(FUNC_STEP));
      push_setting(0, 0);
      push_req(make_req(FUNC_STEP));
      r = make_req(FUNC_READ);
      r.unit = 7'd5;
      push_req(r);
      push_setting(1, 1);
      push_req(make_req(FUNC_STEP));
      r.unit = 7'd0;
      push_req(r);

      // random phases under each idling mode
      for (int p = 0; p < 4; p++) begin
         push_setting(settings[p][0], settings[p][1]);
         push_op(OP_PHASE, 1'b0, 8'd0, idles[p][0], idles[p][1]);
         for (int i = 0; i < 30; i++) begin
            if (p == 1 && i == 15) push_op(OP_HOLD);
            if (p == 2 && i == 15) push_op(OP_DRAIN);
            push_req(random_req());
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0);
      @(posedge clock);
      while (req_valid || sent_cnt != rsp_cnt) @(posedge clock);
      repeat (20) @(posedge clock);
      while (expected_rsp.size() > 0) begin
         void'(expected_rsp.pop_front());
         report_mismatch("expected response never arrived");
      end
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rsu_pkg.sv
rtl/rsu_ram.sv
rtl/reservoir_state_update.sv
tb/reservoir_state_update_tb.sv
